// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define FPX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset
`define FPX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/core/fpx_pkg.sv -----
`default_nettype none

package fpx_pkg;

   localparam int ByteWidth       = 8;
   localparam int LenWidth        = 4;
   localparam int PayloadWidth    = 64;
   localparam int MaxPayloadBytes = 8;

   localparam logic [ByteWidth-1:0] StartMarkerReset = 8'hAA;

   localparam logic StatusOk       = 1'b0;
   localparam logic StatusMismatch = 1'b1;

   typedef enum logic [2:0] {
      PHASE_IDLE  = 3'd0,
      PHASE_CMD   = 3'd1,
      PHASE_LEN   = 3'd2,
      PHASE_DATA  = 3'd3,
      PHASE_CHECK = 3'd4
   } phase_type;

   typedef struct packed {
      logic                    status;
      logic [ByteWidth-1:0]    command;
      logic [LenWidth-1:0]     length;
      logic [PayloadWidth-1:0] payload;
      logic [ByteWidth-1:0]    check;
   } frame_result_type;

endpackage

`default_nettype wire

// ----- rtl/core/fpx_in_reg.sv -----
`default_nettype none

module fpx_in_reg (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [fpx_pkg::ByteWidth-1:0] req_rx_byte,
   input  wire logic                         advance,
   output logic                              byte_valid,
   output logic [fpx_pkg::ByteWidth-1:0]     byte_data
);
   import fpx_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] byte_ff;

   // slot is free when empty or when its item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

`default_nettype wire

// ----- rtl/core/fpx_parser.sv -----
`default_nettype none

module fpx_parser #(
   parameter int MAX_PAYLOAD_BYTES = fpx_pkg::MaxPayloadBytes
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [fpx_pkg::ByteWidth-1:0] csr_write_data,
   input  wire logic                          byte_valid,
   input  wire logic                          advance,
   input  wire logic [fpx_pkg::ByteWidth-1:0] byte_data,
   output logic                               result_valid,
   output fpx_pkg::frame_result_type          result
);
   import fpx_pkg::*;

   logic                 step;
   phase_type            phase_ff, phase_in;
   logic [ByteWidth-1:0] marker_ff;
   logic [ByteWidth-1:0] command_ff, command_in;
   logic [LenWidth-1:0]  length_ff, length_in;
   logic [LenWidth-1:0]  position_ff, position_in;
   logic [ByteWidth-1:0] xor_ff, xor_in;
   logic [ByteWidth-1:0] store_ff [MAX_PAYLOAD_BYTES];
   logic [ByteWidth-1:0] store_in [MAX_PAYLOAD_BYTES];
   logic [LenWidth-1:0]  position_next;
   logic                 store_clear;
   logic                 store_write;
   logic [PayloadWidth-1:0] packed_payload;

   assign step = byte_valid && advance;

   // pack stored payload, bytes at or past the length read as zero
   always_comb begin
      packed_payload = '0;
      for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
         if (LenWidth'(i) < length_ff) begin
            packed_payload[ByteWidth*i +: ByteWidth] = store_ff[i];
         end
      end
   end

   assign position_next = position_ff + LenWidth'(1);

   // phase decode and state updates for one byte
   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      position_in  = position_ff;
      xor_in       = xor_ff;
      store_clear  = 1'b0;
      store_write  = 1'b0;
      result_valid = 1'b0;
      result.status  = (xor_ff == byte_data) ? StatusOk : StatusMismatch;
      result.command = command_ff;
      result.length  = length_ff;
      result.payload = packed_payload;
      result.check   = byte_data;
      unique case (phase_ff)
         PHASE_CMD: begin
            command_in = byte_data;
            xor_in     = byte_data;
            phase_in   = PHASE_LEN;
         end
         PHASE_LEN: begin
            if (byte_data > ByteWidth'(MAX_PAYLOAD_BYTES)) begin
               // oversized frame is dropped silently
               phase_in = PHASE_IDLE;
            end else begin
               length_in   = byte_data[LenWidth-1:0];
               xor_in      = xor_ff ^ byte_data;
               position_in = '0;
               phase_in    = (byte_data == '0) ? PHASE_CHECK : PHASE_DATA;
            end
         end
         PHASE_DATA: begin
            store_write = 1'b1;
            xor_in      = xor_ff ^ byte_data;
            position_in = position_next;
            if (position_next >= length_ff) begin
               phase_in = PHASE_CHECK;
            end
         end
         PHASE_CHECK: begin
            result_valid = step;
            phase_in     = PHASE_IDLE;
         end
         default: begin
            // idle and unused codes hunt for the start byte
            if (byte_data == marker_ff) begin
               store_clear = 1'b1;
               position_in = '0;
               xor_in      = '0;
               phase_in    = PHASE_CMD;
            end else begin
               phase_in = PHASE_IDLE;
            end
         end
      endcase
   end

   // payload lanes, each written only at its own position, all cleared at a start byte
   always_comb begin
      for (int j = 0; j < MAX_PAYLOAD_BYTES; j++) begin
         if (store_clear) begin
            store_in[j] = '0;
         end else if (store_write && position_ff == LenWidth'(j)) begin
            store_in[j] = byte_data;
         end else begin
            store_in[j] = store_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_IDLE;
         marker_ff <= StartMarkerReset;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
         end
         if (csr_write_en) begin
            marker_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         command_ff  <= command_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         xor_ff      <= xor_in;
         for (int j = 0; j < MAX_PAYLOAD_BYTES; j++) begin
            store_ff[j] <= store_in[j];
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/fpx_rsp_reg.sv -----
`default_nettype none

module fpx_rsp_reg (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             result_valid,
   input  wire fpx_pkg::frame_result_type        result,
   output logic                                  advance,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_frame_status,
   output logic [fpx_pkg::ByteWidth-1:0]         rsp_frame_command,
   output logic [fpx_pkg::LenWidth-1:0]          rsp_frame_length,
   output logic [fpx_pkg::PayloadWidth-1:0]      rsp_frame_payload,
   output logic [fpx_pkg::ByteWidth-1:0]         rsp_received_check
);
   import fpx_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   frame_result_type result_ff;

   // register takes a new item when empty or when the receiver takes the old one
   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? result_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_frame_status   = result_ff.status;
   assign rsp_frame_command  = result_ff.command;
   assign rsp_frame_length   = result_ff.length;
   assign rsp_frame_payload  = result_ff.payload;
   assign rsp_received_check = result_ff.check;

endmodule

`default_nettype wire

// ----- rtl/core/framed_packet_parser_xor_check.sv -----
// Framed packet parser with XOR check.
// req channel: one received byte per item (req_rx_byte), valid/ready.
// rsp channel: one item per complete frame: status (0 match, 1 mismatch),
//   command, length, payload packed byte 0 in bits 7..0 with unused bytes
//   zero, and the check byte as received. Oversized frames give no item.
// csr port: csr_write_en/csr_write_data load the start marker (reset 0xAA);
//   write it only while no frame is in flight.
// The item for a frame passes from the input register through the parse
//   logic, which loads the result register when the check byte steps.
// Throughput: one byte per cycle while the receiver does not stall; the
//   running XOR and phase register are updated once per byte.
// Reset (synchronous, active high) empties both registers, returns the
//   parser to idle and restores the start marker.
// When the receiver stalls, the result register holds its item and the
//   input register still takes one more byte; req_ready then drops until
//   the result is taken.
`default_nettype none
`include "assert_macros.svh"

module framed_packet_parser_xor_check #(
   parameter int MAX_PAYLOAD_BYTES = fpx_pkg::MaxPayloadBytes
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [fpx_pkg::ByteWidth-1:0]   req_rx_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_frame_status,
   output logic [fpx_pkg::ByteWidth-1:0]        rsp_frame_command,
   output logic [fpx_pkg::LenWidth-1:0]         rsp_frame_length,
   output logic [fpx_pkg::PayloadWidth-1:0]     rsp_frame_payload,
   output logic [fpx_pkg::ByteWidth-1:0]        rsp_received_check,
   input  wire logic                            csr_write_en,
   input  wire logic [fpx_pkg::ByteWidth-1:0]   csr_write_data
);
   import fpx_pkg::*;

   logic                 advance;
   logic                 byte_valid;
   logic [ByteWidth-1:0] byte_data;
   logic                 result_valid;
   frame_result_type     result;

   fpx_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   fpx_parser #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .byte_valid     (byte_valid),
      .advance        (advance),
      .byte_data      (byte_data),
      .result_valid   (result_valid),
      .result         (result)
   );

   fpx_rsp_reg u_rsp_reg (
      .clock              (clock),
      .reset              (reset),
      .result_valid       (result_valid),
      .result             (result),
      .advance            (advance),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_frame_command  (rsp_frame_command),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_frame_payload  (rsp_frame_payload),
      .rsp_received_check (rsp_received_check)
   );

   // input side only backs up behind a stalled result
   `FPX_ASSERT_NOW(a_ready_low_only_on_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // a finished frame always lands in the result register
   `FPX_ASSERT_NEXT(a_result_lands, clock, reset, result_valid, rsp_valid)

   // reported length never exceeds the payload capacity
   `FPX_ASSERT_NOW(a_length_bound, clock, reset, rsp_valid, rsp_frame_length <= LenWidth'(MAX_PAYLOAD_BYTES))

endmodule

`default_nettype wire
